// ===== src/tphts_pkg.sv =====
`default_nettype none

package tphts_pkg;

    // Patch geometry and table size
    localparam int TOWER_SLOTS = 16;
    localparam int TABLE_DEPTH = 4096;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Field widths
    localparam int SLOT_W   = 4;
    localparam int ADC_W    = 12;
    localparam int ADDR_W   = 12;
    localparam int TDATA_W  = 6;
    localparam int DELTA_W  = 10;
    localparam int SUM_W    = 14;
    localparam int HT_W     = 11;
    localparam int PV_W     = 6;
    localparam int PACKED_W = 12;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // Saturation limits of the running sum and the largest table index
    localparam logic signed [SUM_W:0]   SUM_MAX = (SUM_W + 1)'(8191);
    localparam logic signed [SUM_W:0]   SUM_MIN = -(SUM_W + 1)'(8192);
    localparam logic signed [SUM_W-1:0] IDX_MAX = SUM_W'(TABLE_DEPTH - 1);

    // Item kinds (tuser)
    localparam logic KIND_SAMPLE      = 1'b0;
    localparam logic KIND_TABLE_WRITE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PEDESTAL_VALUES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEDESTAL_SUB_MASK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOWER_ENABLE_MASK = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_CONV_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_TOWER_EN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PATCH_SUM_EN      = 3'd5;

    typedef struct packed {
        logic [63:0] pedestal_values;
        logic [15:0] pedestal_subtract_mask;
        logic [15:0] tower_enable_mask;
        logic [2:0]  bit_conversion_mode;
        logic        high_tower_enable;
        logic        patch_sum_enable;
    } cfg_t;

    // One classified item waiting for the back end
    typedef struct packed {
        logic                      kind;
        logic                      last;
        logic                      tower_ok;
        logic signed [DELTA_W-1:0] delta;
        logic [HT_W-1:0]           val;
        logic                      addr_ok;
        logic [ADDR_W-1:0]         table_address;
        logic [TDATA_W-1:0]        table_data;
    } qentry_t;

endpackage

`default_nettype wire

// ===== src/tphts_front.sv =====
`default_nettype none

module tphts_front
(
    input  wire tphts_pkg::cfg_t                  cfg,
    input  wire logic                             in_kind,
    input  wire logic [tphts_pkg::SLOT_W-1:0]     in_slot,
    input  wire logic [tphts_pkg::ADC_W-1:0]      in_adc_raw,
    input  wire logic                             in_last,
    input  wire logic [tphts_pkg::ADDR_W-1:0]     in_table_address,
    input  wire logic [tphts_pkg::TDATA_W-1:0]    in_table_data,
    output tphts_pkg::qentry_t                    entry
);

    logic                          slot_ok;
    logic [3:0]                    ped;
    logic signed [11:0]            base;
    logic signed [11:0]            v;
    logic signed [11:0]            v_q;
    logic signed [11:0]            v_d;
    logic                          q_ovf;

    // Pick this slot's pedestal and form the corrected value
    assign slot_ok = ({1'b0, in_slot} < 5'(tphts_pkg::TOWER_SLOTS));
    assign ped     = cfg.pedestal_values[{in_slot, 2'b00} +: 4];
    assign base    = $signed({2'b00, in_adc_raw[11:2]});
    assign v       = cfg.pedestal_subtract_mask[in_slot] ? (base - $signed({8'b0, ped}))
                                                         : (base + $signed({8'b0, ped}));

    // Sum contribution and compressed candidate
    assign v_d   = v >>> 2;
    assign v_q   = v >>> cfg.bit_conversion_mode;
    assign q_ovf = (v_q[11:5] != 7'b0);

    always_comb
    begin
        entry               = '0;
        entry.kind          = in_kind;
        entry.last          = in_last;
        entry.tower_ok      = slot_ok && cfg.tower_enable_mask[in_slot];
        entry.delta         = v_d[tphts_pkg::DELTA_W-1:0];
        entry.addr_ok       = ({1'b0, in_table_address} < 13'(tphts_pkg::TABLE_DEPTH));
        entry.table_address = in_table_address;
        entry.table_data    = in_table_data;
        if (cfg.bit_conversion_mode != 3'd0)
        begin
            entry.val = {5'b0, q_ovf, v_q[4:0]};
        end
        else if (v > 12'sd0)
        begin
            entry.val = v[tphts_pkg::HT_W-1:0];
        end
        else
        begin
            entry.val = '0;
        end
    end

endmodule

`default_nettype wire

// ===== src/tphts_queue.sv =====
`default_nettype none

module tphts_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire tphts_pkg::qentry_t push_data,
    output logic                    ready,
    input  wire logic               pop,
    output logic                    head_valid,
    output tphts_pkg::qentry_t      head
);

    tphts_pkg::qentry_t                  entries [tphts_pkg::QUEUE_DEPTH];
    logic [tphts_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [tphts_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [tphts_pkg::QPTR_W:0]          count_reg;
    logic [tphts_pkg::QPTR_W:0]          count_next;

    assign ready      = (count_reg != (tphts_pkg::QPTR_W + 1)'(tphts_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store item payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/tphts_back.sv =====
`default_nettype none

module tphts_back
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tphts_pkg::cfg_t                     cfg,
    input  wire logic                                head_valid,
    input  wire tphts_pkg::qentry_t                  head,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [tphts_pkg::HT_W-1:0]               out_high_tower,
    output logic [tphts_pkg::PV_W-1:0]               out_patch_value,
    output logic [tphts_pkg::PACKED_W-1:0]           out_packed_word
);

    logic [tphts_pkg::PV_W-1:0]        sum_table [tphts_pkg::TABLE_DEPTH];
    logic [tphts_pkg::PV_W-1:0]        rdata_reg;

    logic signed [tphts_pkg::SUM_W-1:0] sum_reg;
    logic signed [tphts_pkg::SUM_W-1:0] sum_next;
    logic [tphts_pkg::HT_W-1:0]         max_reg;
    logic [tphts_pkg::HT_W-1:0]         max_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [tphts_pkg::HT_W-1:0]         ht_reg;
    logic                               pse_reg;

    logic                               out_free;
    logic                               is_sample;
    logic                               closes;
    logic signed [tphts_pkg::SUM_W:0]   sum_wide;
    logic signed [tphts_pkg::SUM_W-1:0] sum_upd;
    logic [tphts_pkg::HT_W-1:0]         max_upd;
    logic                               tbl_we;
    logic                               tbl_re;
    logic [tphts_pkg::TBL_AW-1:0]       raddr;
    logic [tphts_pkg::PV_W-1:0]         pv;

    // Pop unless a closing sample would overrun a held result
    assign out_free  = !out_valid_reg || out_ready;
    assign is_sample = (head.kind == tphts_pkg::KIND_SAMPLE);
    assign pop       = head_valid && (!(is_sample && head.last) || out_free);
    assign closes    = pop && is_sample && head.last;
    assign tbl_we    = pop && (head.kind == tphts_pkg::KIND_TABLE_WRITE) && head.addr_ok;
    assign tbl_re    = closes;

    // Saturating sum and running maximum for this sample
    assign sum_wide = (tphts_pkg::SUM_W + 1)'(sum_reg) + (tphts_pkg::SUM_W + 1)'(head.delta);

    always_comb
    begin
        sum_upd = sum_reg;
        max_upd = max_reg;
        if (head.tower_ok)
        begin
            if (sum_wide > tphts_pkg::SUM_MAX)
            begin
                sum_upd = tphts_pkg::SUM_MAX[tphts_pkg::SUM_W-1:0];
            end
            else if (sum_wide < tphts_pkg::SUM_MIN)
            begin
                sum_upd = tphts_pkg::SUM_MIN[tphts_pkg::SUM_W-1:0];
            end
            else
            begin
                sum_upd = sum_wide[tphts_pkg::SUM_W-1:0];
            end
            if (head.val > max_reg)
            begin
                max_upd = head.val;
            end
        end
    end

    // Clamp the closing sum to a table index
    always_comb
    begin
        if (sum_upd < 0)
        begin
            raddr = '0;
        end
        else if (sum_upd > tphts_pkg::IDX_MAX)
        begin
            raddr = tphts_pkg::IDX_MAX[tphts_pkg::TBL_AW-1:0];
        end
        else
        begin
            raddr = sum_upd[tphts_pkg::TBL_AW-1:0];
        end
    end

    always_comb
    begin
        sum_next       = sum_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop && is_sample)
        begin
            if (head.last)
            begin
                sum_next       = '0;
                max_next       = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                sum_next = sum_upd;
                max_next = max_upd;
            end
        end
    end

    // Hold accumulators and the result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Latch result payload when an event closes
    always_ff @(posedge clk)
    begin
        if (closes)
        begin
            ht_reg  <= cfg.high_tower_enable ? max_upd : '0;
            pse_reg <= cfg.patch_sum_enable;
        end
    end

    // Lookup table: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            sum_table[head.table_address[tphts_pkg::TBL_AW-1:0]] <= head.table_data;
        end
        if (tbl_re)
        begin
            rdata_reg <= sum_table[raddr];
        end
    end

    assign pv              = pse_reg ? rdata_reg : '0;
    assign out_valid       = out_valid_reg;
    assign out_high_tower  = ht_reg;
    assign out_patch_value = pv;
    assign out_packed_word = tphts_pkg::PACKED_W'(ht_reg) | {pv, 6'b0};

endmodule

`default_nettype wire

// ===== src/trigger_patch_high_tower_sum.sv =====
// Channel     Handshake                    Payload
// s_axis      tvalid/tready                tdata: slot, adc_raw, table_address, table_data
//                                          tlast: last, tuser: kind
// m_axis      tvalid/tready                tdata: high_tower, patch_value, packed_word
// cfg         cfg_wr_en (no wait)          cfg_index, cfg_data
//
// One item per cycle in while the queue has room; a closing sample's result is registered once it leaves the queue.
// The front classifies and pre-computes, a four-entry queue feeds the back end,
// which accumulates and reads the lookup table through its single registered port.
// A closing sample waits in the queue only while a result is held by m_axis_tready.
// Reset clears accumulators, queue and result flag; the table holds anything until loaded.
`default_nettype none

module trigger_patch_high_tower_sum
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    input  wire logic [tphts_pkg::S_TDATA_W-1:0]       s_axis_tdata,  // slot, adc_raw, table_address, table_data
    input  wire logic                                  s_axis_tlast,
    input  wire logic                                  s_axis_tuser,  // kind
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output logic [tphts_pkg::M_TDATA_W-1:0]            m_axis_tdata,  // high_tower, patch_value, packed_word
    input  wire logic                                  cfg_wr_en,
    input  wire logic [tphts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tphts_pkg::CFG_DAT_W-1:0]       cfg_data
);

    tphts_pkg::cfg_t                   cfg_reg;
    tphts_pkg::qentry_t                entry;
    tphts_pkg::qentry_t                head;
    logic                              head_valid;
    logic                              pop;
    logic                              push;
    logic [tphts_pkg::HT_W-1:0]        high_tower;
    logic [tphts_pkg::PV_W-1:0]        patch_value;
    logic [tphts_pkg::PACKED_W-1:0]    packed_word;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tphts_pkg::REG_PEDESTAL_VALUES:   cfg_reg.pedestal_values        <= cfg_data;
                tphts_pkg::REG_PEDESTAL_SUB_MASK: cfg_reg.pedestal_subtract_mask <= cfg_data[15:0];
                tphts_pkg::REG_TOWER_ENABLE_MASK: cfg_reg.tower_enable_mask      <= cfg_data[15:0];
                tphts_pkg::REG_BIT_CONV_MODE:     cfg_reg.bit_conversion_mode    <= cfg_data[2:0];
                tphts_pkg::REG_HIGH_TOWER_EN:     cfg_reg.high_tower_enable      <= cfg_data[0];
                tphts_pkg::REG_PATCH_SUM_EN:      cfg_reg.patch_sum_enable       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign push = s_axis_tvalid && s_axis_tready;

    tphts_front u_front
    (
        .cfg              (cfg_reg),
        .in_kind          (s_axis_tuser),
        .in_slot          (s_axis_tdata[3:0]),
        .in_adc_raw       (s_axis_tdata[15:4]),
        .in_last          (s_axis_tlast),
        .in_table_address (s_axis_tdata[27:16]),
        .in_table_data    (s_axis_tdata[33:28]),
        .entry            (entry)
    );

    tphts_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (entry),
        .ready      (s_axis_tready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tphts_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_high_tower  (high_tower),
        .out_patch_value (patch_value),
        .out_packed_word (packed_word)
    );

    assign m_axis_tdata = {3'b000, packed_word, patch_value, high_tower};

endmodule

`default_nettype wire

// ===== src/tphts_checker.sv =====
`default_nettype none

module tphts_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [31:0] m_axis_tdata
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Packed word agrees with high tower and patch value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:17] == m_axis_tdata[5:0])
                       && (m_axis_tdata[27:23] == (m_axis_tdata[10:6] | m_axis_tdata[15:11]))
                       && (m_axis_tdata[28] == m_axis_tdata[16])
                       && (m_axis_tdata[31:29] == 3'b000))
        else $error("packed word inconsistent");

    // No result while in reset
    assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind trigger_patch_high_tower_sum tphts_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // One reported patch result
    typedef struct {
        logic [tphts_pkg::HT_W-1:0]     high_tower;
        logic [tphts_pkg::PV_W-1:0]     patch_value;
        logic [tphts_pkg::PACKED_W-1:0] packed_word;
    } patch_result_t;

    // Tracks the patch state and the results the block owes us
    class patch_scoreboard;
        logic [63:0]                ped_values;
        logic [15:0]                sub_mask;
        logic [15:0]                tower_enable_mask;
        logic [2:0]                 conv_mode;
        logic                       ht_en;
        logic                       ps_en;
        logic [tphts_pkg::PV_W-1:0] sum_table [tphts_pkg::TABLE_DEPTH];
        bit                         written [tphts_pkg::TABLE_DEPTH];
        int                         patch_sum;
        int                         patch_max;
        patch_result_t              pending [$];
        int                         errors;

        function new();
            ped_values = '0;
            sub_mask = '0;
            tower_enable_mask = '0;
            conv_mode = '0;
            ht_en = 1'b0;
            ps_en = 1'b0;
            patch_sum = 0;
            patch_max = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [tphts_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
            case (idx)
                tphts_pkg::REG_PEDESTAL_VALUES:   ped_values = val;
                tphts_pkg::REG_PEDESTAL_SUB_MASK: sub_mask = val[15:0];
                tphts_pkg::REG_TOWER_ENABLE_MASK: tower_enable_mask = val[15:0];
                tphts_pkg::REG_BIT_CONV_MODE:     conv_mode = val[2:0];
                tphts_pkg::REG_HIGH_TOWER_EN:     ht_en = val[0];
                tphts_pkg::REG_PATCH_SUM_EN:      ps_en = val[0];
                default: ;
            endcase
        endfunction

        function bit slot_live(logic [3:0] slot);
            return (int'(slot) < tphts_pkg::TOWER_SLOTS) && tower_enable_mask[slot];
        endfunction

        // Cut the ADC to 10 bits and apply the slot pedestal
        function int tower_value(logic [3:0] slot, logic [11:0] adc);
            int ped;
            int v;
            ped = int'(ped_values[4*slot +: 4]);
            v = int'(adc >> 2);
            return sub_mask[slot] ? v - ped : v + ped;
        endfunction

        // Running sum after adding one tower, saturated to 14 bits signed
        function int sum_with(int v);
            int s;
            s = patch_sum + (v >>> 2);
            if (s > 8191)
                s = 8191;
            if (s < -8192)
                s = -8192;
            return s;
        endfunction

        function int clamp_index(int s);
            if (s < 0)
                return 0;
            if (s > tphts_pkg::TABLE_DEPTH - 1)
                return tphts_pkg::TABLE_DEPTH - 1;
            return s;
        endfunction

        // Table index that a closing sample would look up
        function int peek_index(logic [3:0] slot, logic [11:0] adc);
            int s;
            s = patch_sum;
            if (slot_live(slot))
                s = sum_with(tower_value(slot, adc));
            return clamp_index(s);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void note_item(logic kind, logic [3:0] slot, logic [11:0] adc, logic last,
                                logic [11:0] addr, logic [5:0] data);
            int v;
            int q;
            int val;
            patch_result_t r;
            // Table load: no result, last is ignored
            if (kind == tphts_pkg::KIND_TABLE_WRITE)
            begin
                if (int'(addr) < tphts_pkg::TABLE_DEPTH)
                begin
                    sum_table[addr] = data;
                    written[addr] = 1'b1;
                end
                return;
            end
            // Accumulate an enabled tower
            if (slot_live(slot))
            begin
                v = tower_value(slot, adc);
                patch_sum = sum_with(v);
                val = -1;
                if (conv_mode != 0)
                begin
                    q = v >>> conv_mode;
                    val = q & 'h1f;
                    if (q < 0 || q > 'h1f)
                        val = val | 'h20;
                end
                else if (v > 0)
                begin
                    val = v;
                end
                if (val > patch_max)
                    patch_max = val & 'h7ff;
            end
            if (!last)
                return;
            // Close the event
            r.high_tower = ht_en ? tphts_pkg::HT_W'(patch_max) : '0;
            r.patch_value = ps_en ? sum_table[clamp_index(patch_sum)] : '0;
            r.packed_word = tphts_pkg::PACKED_W'(r.high_tower)
                          | (tphts_pkg::PACKED_W'(r.patch_value) << 6);
            pending.push_back(r);
            patch_sum = 0;
            patch_max = 0;
        endfunction

        function void check_result(logic [tphts_pkg::HT_W-1:0] ht,
                                   logic [tphts_pkg::PV_W-1:0] pv,
                                   logic [tphts_pkg::PACKED_W-1:0] pw);
            patch_result_t e;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result ht=%0d pv=%0d pw=%0h", ht, pv, pw));
                return;
            end
            e = pending.pop_front();
            if (ht !== e.high_tower)
                report($sformatf("high_tower expected %0d got %0d", e.high_tower, ht));
            if (pv !== e.patch_value)
                report($sformatf("patch_value expected %0d got %0d", e.patch_value, pv));
            if (pw !== e.packed_word)
                report($sformatf("packed_word expected %0h got %0h", e.packed_word, pw));
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b1;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [tphts_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;  // slot, adc_raw, table_address, table_data
    logic                              s_axis_tlast = 1'b0;
    logic                              s_axis_tuser = 1'b0;  // kind
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [tphts_pkg::M_TDATA_W-1:0]   m_axis_tdata;  // high_tower, patch_value, packed_word
    logic                              cfg_wr_en = 1'b0;
    logic [tphts_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [tphts_pkg::CFG_DAT_W-1:0]   cfg_data = '0;

    patch_scoreboard sb;
    int  items_sent = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_go = 1'b0;
    bit  hold_rx = 1'b0;

    trigger_patch_high_tower_sum dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver readiness, random unless held off
    always @(posedge clk)
    begin
        m_axis_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (300) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[10:0], m_axis_tdata[16:11], m_axis_tdata[28:17]);
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic put_reg(logic [tphts_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic write_config(logic [63:0] ped, logic [15:0] sub, logic [15:0] en,
                                logic [2:0] mode, logic hte, logic pse);
        put_reg(tphts_pkg::REG_PEDESTAL_VALUES, ped);
        put_reg(tphts_pkg::REG_PEDESTAL_SUB_MASK, 64'(sub));
        put_reg(tphts_pkg::REG_TOWER_ENABLE_MASK, 64'(en));
        put_reg(tphts_pkg::REG_BIT_CONV_MODE, 64'(mode));
        put_reg(tphts_pkg::REG_HIGH_TOWER_EN, 64'(hte));
        put_reg(tphts_pkg::REG_PATCH_SUM_EN, 64'(pse));
        cfg_wr_en <= 1'b0;
    endtask

    // Offer one item, hold it until taken, then maybe idle
    task automatic send_item(logic kind, logic [3:0] slot, logic [11:0] adc, logic last,
                             logic [11:0] addr, logic [5:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'b0, data, addr, adc, slot};
        s_axis_tlast <= last;
        s_axis_tuser <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(kind, slot, adc, last, addr, data);
        items_sent++;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Closing sample; load the table entry it will read if still blank
    task automatic close_event(logic [3:0] slot, logic [11:0] adc);
        int idx;
        idx = sb.peek_index(slot, adc);
        if (sb.ps_en && !sb.written[idx])
            send_item(tphts_pkg::KIND_TABLE_WRITE, 4'($urandom), 12'($urandom), 1'b0,
                      12'(idx), 6'($urandom));
        send_item(tphts_pkg::KIND_SAMPLE, slot, adc, 1'b1, 12'($urandom), 6'($urandom));
    endtask

    // Drop valid, drain expected results, let the pipeline empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int          phase_start;
        int          len;
        bit          long_ev;
        logic [3:0]  slot;
        logic [11:0] adc;
        logic [15:0] en;

        sb = new();
        #1 rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pedestal add and subtract, disabled slot, table extremes
        write_config('1, 16'haaaa, 16'h7fff, 3'd0, 1'b1, 1'b1);
        send_item(tphts_pkg::KIND_TABLE_WRITE, 4'd0, 12'd0, 1'b0, 12'd0, 6'd63);
        send_item(tphts_pkg::KIND_TABLE_WRITE, 4'd15, 12'hfff, 1'b1, 12'hfff, 6'h15);
        send_item(tphts_pkg::KIND_SAMPLE, 4'd0, 12'hfff, 1'b0, 12'd0, 6'd0);
        send_item(tphts_pkg::KIND_SAMPLE, 4'd1, 12'd0, 1'b0, 12'hfff, 6'h3f);
        close_event(4'd15, 12'hfff);
        close_event(4'd1, 12'd0);
        close_event(4'd15, 12'hfff);
        settle();

        // Directed: negative tower with compression wins the maximum
        write_config('1, 16'hffff, 16'hffff, 3'd3, 1'b1, 1'b0);
        send_item(tphts_pkg::KIND_SAMPLE, 4'd2, 12'd0, 1'b0, 12'd0, 6'd0);
        close_event(4'd4, 12'hfff);
        close_event(4'd3, 12'd0);
        settle();

        // Directed: widest shift, high tower forced off
        write_config('0, 16'h0000, 16'hffff, 3'd7, 1'b0, 1'b1);
        close_event(4'd5, 12'hfff);
        send_item(tphts_pkg::KIND_SAMPLE, 4'd9, 12'h800, 1'b0, 12'd0, 6'd0);
        close_event(4'd14, 12'h7ff);
        settle();

        // Random phases, each with its own settings; the idling pattern changes every three phases
        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 15;
                    recv_idle_pct <= 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct <= 15;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            case (phase)
                1: write_config('1, 16'hffff, 16'hffff, 3'd7, 1'b1, 1'b1);
                2: write_config({$urandom, $urandom}, 16'($urandom), 16'h8001,
                                3'($urandom_range(7)), 1'b1, 1'b1);
                4: write_config('0, 16'h0000, 16'hffff, 3'd0, 1'b1, 1'b1);
                7: write_config('1, 16'hffff, 16'hffff, 3'd1, 1'b1, 1'b1);
                default: write_config({$urandom, $urandom}, 16'($urandom),
                                      16'($urandom) | 16'h0101, 3'($urandom_range(7)),
                                      $urandom_range(99) < 75, $urandom_range(99) < 80);
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 158)
            begin
                if (phase == 6 && items_sent - phase_start > 20)
                    hold_go = 1'b1;
                // Long events push the sum into saturation
                long_ev = $urandom_range(99) < 6;
                len = long_ev ? $urandom_range(20, 45) : $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(99) < 8)
                        send_item(tphts_pkg::KIND_TABLE_WRITE, 4'($urandom), 12'($urandom),
                                  1'($urandom), 12'($urandom), 6'($urandom));
                    en = sb.tower_enable_mask;
                    slot = 4'($urandom);
                    if (en != 0 && $urandom_range(99) < 85)
                        while (!en[slot])
                            slot = 4'($urandom);
                    case ($urandom_range(6))
                        0: adc = 12'd0;
                        1: adc = 12'hfff;
                        default: adc = 12'($urandom);
                    endcase
                    if (long_ev)
                        adc = 12'($urandom_range(3800, 4095));
                    if (i == len - 1)
                        close_event(slot, adc);
                    else
                        send_item(tphts_pkg::KIND_SAMPLE, slot, adc, 1'b0, 12'($urandom),
                                  6'($urandom));
                end
            end
            settle();
        end

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
